@@ src/mtat_pkg.sv @@
// Package: shared types, constants and register codes of the multi-turn angle tracker.
package mtat_pkg;

  // Encoder word width, fixed by the item layout
  localparam int ANGLE_BITS = 14;
  localparam int POS_BITS   = 32;
  localparam int ID_BITS    = 11;

  // Default report cadence, in samples
  localparam int REPORT_PERIOD_DEF = 10;
  localparam int ERROR_PERIOD_DEF  = 100;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Command codes of an input word
  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_FRAME  = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_RANGE_LIMIT  = 3'd0;
  localparam logic [2:0] REG_IGN_TIMEOUT  = 3'd1;
  localparam logic [2:0] REG_RESET_ID     = 3'd2;
  localparam logic [2:0] REG_IGN_ID       = 3'd3;
  localparam logic [2:0] REG_ANGLE_REP_ID = 3'd4;
  localparam logic [2:0] REG_ERROR_REP_ID = 3'd5;

  // Register reset values
  localparam logic [30:0] RANGE_LIMIT_RST   = 31'd49149;
  localparam logic [15:0] IGN_TIMEOUT_RST   = 16'd500;
  localparam logic [10:0] RESET_ID_RST      = 11'h230;
  localparam logic [10:0] IGN_ID_RST        = 11'h001;
  localparam logic [10:0] ANGLE_REP_ID_RST  = 11'h023;
  localparam logic [10:0] ERROR_REP_ID_RST  = 11'h231;

  // Clear frame contents
  localparam logic [63:0] CLEAR_PATTERN  = 64'h0D0E_0A0D_0F0A_0C0E;
  localparam logic [3:0]  FRAME_LEN_FULL = 4'd8;

  // Report lengths
  localparam logic [3:0] LEN_POSITION = 4'd8;
  localparam logic [3:0] LEN_ERROR    = 4'd1;

  // Input word
  typedef struct packed {
    logic [1:0]            cmd;
    logic [ANGLE_BITS-1:0] raw_angle;
    logic [ID_BITS-1:0]    frame_id;
    logic [3:0]            frame_len;
    logic [63:0]           frame_data;
  } item_word_t;

  // Output word
  typedef struct packed {
    logic [ID_BITS-1:0] report_id;
    logic [3:0]         report_len;
    logic [63:0]        report_data;
    logic               last;
  } report_word_t;

  // Configuration register set
  typedef struct packed {
    logic [30:0]        range_limit;
    logic [15:0]        ignition_timeout;
    logic [ID_BITS-1:0] reset_frame_id;
    logic [ID_BITS-1:0] ignition_frame_id;
    logic [ID_BITS-1:0] angle_report_id;
    logic [ID_BITS-1:0] error_report_id;
  } cfg_t;

  // Classified operation handed from front to back
  typedef enum logic [1:0] {
    OP_SAMPLE,
    OP_FRAME,
    OP_TICK
  } op_kind_t;

  typedef struct packed {
    op_kind_t              kind;
    logic [ANGLE_BITS-1:0] angle;
    logic                  clear_hit;
    logic                  ign_hit;
  } op_t;

endpackage

@@ src/mtat_front.sv @@
// Front end: configuration registers, input acceptance and item classification.
module mtat_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  mtat_pkg::item_word_t item,
  output logic                 push_valid,
  input  logic                 push_ready,
  output mtat_pkg::op_t        push_op,
  output mtat_pkg::cfg_t       cfg
);
  import mtat_pkg::*;

  cfg_t cfg_reg;

  assign cfg_ready  = 1'b1;
  assign cfg        = cfg_reg;
  assign item_ready = push_ready;

  // Configuration writes, masked to register width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg.range_limit       <= RANGE_LIMIT_RST;
      cfg_reg.ignition_timeout  <= IGN_TIMEOUT_RST;
      cfg_reg.reset_frame_id    <= RESET_ID_RST;
      cfg_reg.ignition_frame_id <= IGN_ID_RST;
      cfg_reg.angle_report_id   <= ANGLE_REP_ID_RST;
      cfg_reg.error_report_id   <= ERROR_REP_ID_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_RANGE_LIMIT:  cfg_reg.range_limit       <= cfg_data[30:0];
        REG_IGN_TIMEOUT:  cfg_reg.ignition_timeout  <= cfg_data[15:0];
        REG_RESET_ID:     cfg_reg.reset_frame_id    <= cfg_data[ID_BITS-1:0];
        REG_IGN_ID:       cfg_reg.ignition_frame_id <= cfg_data[ID_BITS-1:0];
        REG_ANGLE_REP_ID: cfg_reg.angle_report_id   <= cfg_data[ID_BITS-1:0];
        REG_ERROR_REP_ID: cfg_reg.error_report_id   <= cfg_data[ID_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Classify the word; unused command is accepted and dropped
  always_comb begin
    push_op.angle     = item.raw_angle;
    push_op.clear_hit = (item.frame_id == cfg_reg.reset_frame_id) &&
                        (item.frame_len == FRAME_LEN_FULL) &&
                        (item.frame_data == CLEAR_PATTERN);
    push_op.ign_hit   = (item.frame_id == cfg_reg.ignition_frame_id);
    push_valid        = item_valid;
    unique case (item.cmd)
      CMD_SAMPLE: push_op.kind = OP_SAMPLE;
      CMD_FRAME:  push_op.kind = OP_FRAME;
      CMD_TICK:   push_op.kind = OP_TICK;
      default: begin
        push_op.kind = OP_TICK;
        push_valid   = 1'b0;
      end
    endcase
  end

endmodule

@@ src/mtat_queue.sv @@
// Short register queue between front and back.
module mtat_queue #(
  parameter int DEPTH = mtat_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  mtat_pkg::op_t push_op,
  output logic          pop_valid,
  input  logic          pop_ready,
  output mtat_pkg::op_t pop_op
);
  import mtat_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
  localparam logic [AW:0]   CNT_FULL = (AW + 1)'(DEPTH);

  op_t         entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != CNT_FULL);
  assign pop_valid  = (count != '0);
  assign pop_op     = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_op;
    end
  end

endmodule

@@ src/mtat_back.sv @@
// Back end: position unwrap, range check, ignition timing and report output.
module mtat_back #(
  parameter int REPORT_PERIOD = mtat_pkg::REPORT_PERIOD_DEF,
  parameter int ERROR_PERIOD  = mtat_pkg::ERROR_PERIOD_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  mtat_pkg::cfg_t         cfg,
  input  logic                   op_valid,
  output logic                   op_ready,
  input  mtat_pkg::op_t          op,
  output logic                   report_valid,
  input  logic                   report_ready,
  output mtat_pkg::report_word_t report
);
  import mtat_pkg::*;

  localparam int PW = (REPORT_PERIOD > 1) ? $clog2(REPORT_PERIOD) : 1;
  localparam logic [PW-1:0] PHASE_LAST = PW'(REPORT_PERIOD - 1);
  localparam logic [6:0]    ERR_COUNT  = 7'(ERROR_PERIOD);

  // Tracker state; the range flag is only ever reported on the sample that sets it
  logic [ANGLE_BITS-1:0] prev_angle;
  logic                  primed;
  logic [POS_BITS-1:0]   position;
  logic                  ignition_on;
  logic [15:0]           since_ignition;
  logic [6:0]            report_counter;
  logic [PW-1:0]         report_phase;

  // Second report of a sample, waiting for the output register
  logic         pend_valid;
  report_word_t pend_word;

  logic                  take;
  logic                  take_sample;
  logic                  out_free;
  logic                  ign_live;
  logic [ANGLE_BITS-1:0] diff;
  logic [POS_BITS-1:0]   position_next;
  logic [POS_BITS-1:0]   neg_limit;
  logic                  range_next;
  logic                  rep_go;
  logic                  rep_pos;
  logic                  rep_err;
  logic [6:0]            counter_base;
  logic [PW-1:0]         phase_base;
  report_word_t          pos_word;
  report_word_t          err_word;
  report_word_t          first_word;

  // Handshake towards the queue
  always_comb begin
    out_free    = !report_valid || report_ready;
    op_ready    = (op.kind != OP_SAMPLE) || (!pend_valid && out_free);
    take        = op_valid && op_ready;
    take_sample = take && (op.kind == OP_SAMPLE);
  end

  // Sample arithmetic: wrap difference, accumulate, check band
  always_comb begin
    ign_live      = ignition_on && !(since_ignition > cfg.ignition_timeout);
    diff          = op.angle - prev_angle;
    position_next = position + {{(POS_BITS - ANGLE_BITS){diff[ANGLE_BITS-1]}}, diff};
    neg_limit     = ~{1'b0, cfg.range_limit} + 1'b1;
    range_next    = ($signed(position_next) > $signed({1'b0, cfg.range_limit})) ||
                    ($signed(position_next) < $signed(neg_limit));
    rep_go        = primed && ign_live;
    rep_pos       = rep_go && (report_phase == '0);
    rep_err       = rep_go && (report_counter == ERR_COUNT);
    counter_base  = (report_counter == ERR_COUNT) ? '0 : report_counter;
    phase_base    = (report_counter == ERR_COUNT) ? '0 : report_phase;
  end

  // Report words
  always_comb begin
    pos_word.report_id   = cfg.angle_report_id;
    pos_word.report_len  = LEN_POSITION;
    pos_word.report_data = {position_next, 32'd0};
    pos_word.last        = !rep_err;
    err_word.report_id   = cfg.error_report_id;
    err_word.report_len  = LEN_ERROR;
    err_word.report_data = {5'd0, range_next, 58'd0};
    err_word.last        = 1'b1;
    first_word           = rep_pos ? pos_word : err_word;
  end

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_angle     <= '0;
      primed         <= 1'b0;
      position       <= '0;
      ignition_on    <= 1'b0;
      since_ignition <= '0;
      report_counter <= '0;
      report_phase   <= '0;
    end else if (take) begin
      unique case (op.kind)
        OP_SAMPLE: begin
          ignition_on <= ign_live;
          prev_angle  <= op.angle;
          primed      <= 1'b1;
          if (primed) begin
            position <= position_next;
          end
          if (rep_go) begin
            report_counter <= counter_base + 1'b1;
            report_phase   <= (phase_base == PHASE_LAST) ? '0 : phase_base + 1'b1;
          end
        end
        OP_FRAME: begin
          if (op.clear_hit) begin
            position <= '0;
          end
          if (op.ign_hit) begin
            ignition_on    <= 1'b1;
            since_ignition <= '0;
          end
        end
        OP_TICK: begin
          if (since_ignition != '1) begin
            since_ignition <= since_ignition + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register and pending slot, control
  always_ff @(posedge clk) begin
    if (rst) begin
      report_valid <= 1'b0;
      pend_valid   <= 1'b0;
    end else begin
      priority if (take_sample && (rep_pos || rep_err)) begin
        report_valid <= 1'b1;
        pend_valid   <= rep_pos && rep_err;
      end else if (pend_valid && out_free) begin
        report_valid <= 1'b1;
        pend_valid   <= 1'b0;
      end else if (report_ready) begin
        report_valid <= 1'b0;
      end
    end
  end

  // Output register and pending slot, payload
  always_ff @(posedge clk) begin
    if (take_sample && (rep_pos || rep_err)) begin
      report    <= first_word;
      pend_word <= err_word;
    end else if (pend_valid && out_free) begin
      report <= pend_word;
    end
  end

endmodule

@@ src/multi_turn_angle_tracker.sv @@
// Top level of the multi-turn angle tracker: front, queue and back joined.
// The block accepts one word per clock while its two-entry queue has room; frames
// and ticks leave the queue at one a clock, samples only while the output register
// is free and no second report is pending. A sample that causes one report needs
// the output register, and a sample that sends both the position and the error
// report also fills the pending slot, so the sustained rate is set by the single
// output register. A sample that is accepted passes through the queue entry and
// the output register before its report appears. Configuration writes are taken
// at once (cfg_ready is tied high) and are meant for an idle block.
module multi_turn_angle_tracker #(
  parameter int REPORT_PERIOD = mtat_pkg::REPORT_PERIOD_DEF,
  parameter int ERROR_PERIOD  = mtat_pkg::ERROR_PERIOD_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [2:0]             cfg_index,
  input  logic [31:0]            cfg_data,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  mtat_pkg::item_word_t   item,
  output logic                   report_valid,
  input  logic                   report_ready,
  output mtat_pkg::report_word_t report
);
  import mtat_pkg::*;

  cfg_t cfg;
  op_t  push_op;
  op_t  pop_op;
  logic push_valid;
  logic push_ready;
  logic pop_valid;
  logic pop_ready;

  mtat_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .cfg        (cfg)
  );

  mtat_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_op     (pop_op)
  );

  mtat_back #(
    .REPORT_PERIOD (REPORT_PERIOD),
    .ERROR_PERIOD  (ERROR_PERIOD)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .op_valid     (pop_valid),
    .op_ready     (pop_ready),
    .op           (pop_op),
    .report_valid (report_valid),
    .report_ready (report_ready),
    .report       (report)
  );

endmodule

@@ src/mtat_checker.sv @@
// Port-level checker for the multi-turn angle tracker, bound to the top level.
module mtat_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   report_valid,
  input logic                   report_ready,
  input mtat_pkg::report_word_t report
);
  import mtat_pkg::*;

  // A stalled report word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    report_valid && !report_ready |=> report_valid && $stable(report))
    else $error("report word changed while stalled");

  // No report straight after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !report_valid)
    else $error("report valid after reset");

  // Only a position report can be followed by another report of the same sample
  a_notlast: assert property (@(posedge clk) disable iff (rst)
    report_valid && !report.last |-> report.report_len == LEN_POSITION)
    else $error("non-final report is not a position report");

  // Position report carries zero in its low bytes
  a_posdata: assert property (@(posedge clk) disable iff (rst)
    report_valid && report.report_len == LEN_POSITION |-> report.report_data[31:0] == '0)
    else $error("position report low bytes not zero");

  // Error report holds only the range bit and is always final
  a_errdata: assert property (@(posedge clk) disable iff (rst)
    report_valid && report.report_len != LEN_POSITION |->
      report.report_len == LEN_ERROR && report.last &&
      report.report_data[63:59] == '0 && report.report_data[57:0] == '0)
    else $error("malformed error report");

endmodule

bind multi_turn_angle_tracker mtat_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .report_valid (report_valid),
  .report_ready (report_ready),
  .report       (report)
);
